>>> src/pn_pkg.sv
// ----------------------------------------------------------------------------
// pn_pkg
// Shared codes, characters and controller/datapath interface types for the
// path normalizer.
// ----------------------------------------------------------------------------
package pn_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    localparam logic [6:0] CAP_RESET = 7'd65;

    typedef enum logic [2:0] {
        S_ACCEPT = 3'b001,
        S_FETCH  = 3'b010,
        S_LOAD   = 3'b100
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic path_done;
        logic out_free;
        logic err_result;
        logic emit_last;
    } t_stat;

endpackage

>>> src/pn_ctrl.sv
// ----------------------------------------------------------------------------
// pn_ctrl
// Sequencer: accepts words until a path ends, then drains the result one
// byte per fetch/load pair.
// ----------------------------------------------------------------------------
module pn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pn_pkg::t_stat i_stat,
    output pn_pkg::t_cmd  o_cmd
);
    import pn_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.in_ready = 1'b0;
        o_cmd.load     = 1'b0;
        unique case (r_state)
            S_ACCEPT: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.path_done) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.err_result || i_stat.emit_last) begin
                        n_state = S_ACCEPT;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            default: n_state = S_ACCEPT;
        endcase
    end

endmodule

>>> src/pn_datapath.sv
// ----------------------------------------------------------------------------
// pn_datapath
// Path store, component start stack, request counters and output register.
// ----------------------------------------------------------------------------
module pn_datapath #(
    parameter int PATH_LIMIT  = 64,
    parameter int LEVEL_LIMIT = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wen,
    input  logic [6:0]    i_cfg_wdata,
    input  logic          i_valid,
    input  logic [7:0]    i_char,
    input  logic          i_is_path,
    input  pn_pkg::t_cmd  i_cmd,
    output pn_pkg::t_stat o_stat,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [7:0]    o_char,
    output logic [6:0]    o_len,
    output logic [1:0]    o_status,
    output logic          o_last
);
    import pn_pkg::*;

    localparam int LW  = $clog2(PATH_LIMIT + 2);
    localparam int AW  = $clog2(PATH_LIMIT);
    localparam int VW  = $clog2(LEVEL_LIMIT);
    localparam int SW  = (LW + 1 > 8) ? LW + 1 : 8;
    localparam logic [LW-1:0] LIM   = LW'(PATH_LIMIT);
    localparam logic [LW-1:0] ONE   = LW'(1);
    localparam logic [VW-1:0] VFULL = VW'(LEVEL_LIMIT - 1);

    logic [7:0]    mem [PATH_LIMIT];
    logic [LW-1:0] stack [LEVEL_LIMIT-1];

    logic [6:0]    r_cap;
    logic [LW-1:0] r_ol, n_ol;
    logic [VW-1:0] r_lvl, n_lvl;
    logic [LW-1:0] r_clen, n_clen;
    logic          r_bad, n_bad, r_dots, n_dots;
    logic [LW-1:0] r_sidx, n_sidx;
    logic [1:0]    r_cerr, n_cerr, r_perr, n_perr;
    logic          r_unroot, n_unroot, r_clong, n_clong, r_plong, n_plong;
    logic          r_in_path, n_in_path, r_rel, n_rel;
    logic [1:0]    r_res_st, n_res_st;
    logic [LW-1:0] r_nlen, n_nlen;
    logic [LW-1:0] r_k;
    logic [7:0]    r_rd;
    logic          r_ov;
    logic [7:0]    r_ochar;
    logic [6:0]    r_olen;
    logic [1:0]    r_ost;
    logic          r_olast;

    logic          acc, do_fin, we, push, done;
    logic [AW-1:0] wa;
    logic [7:0]    wd;
    logic [1:0]    err_cur, fin_err, st;
    logic [LW-1:0] ol_eff, fin_ol, nout;
    logic [VW-1:0] lvl_eff, fin_lvl;
    logic          fin_wr;
    logic [SW-1:0] sum;

    assign acc = i_cmd.in_ready && i_valid && (i_is_path == r_in_path);
    assign err_cur = r_in_path ? r_perr : r_cerr;
    assign ol_eff = (r_in_path && r_sidx == '0 && i_char == CH_SLASH) ? ONE : r_ol;
    assign lvl_eff = (r_in_path && r_sidx == '0 && i_char == CH_SLASH) ? '0 : r_lvl;
    assign nout = ol_eff + ((ol_eff != ONE) ? ONE : '0);
    assign sum = SW'(nout) + SW'(r_clen);

    // Close the open component: "." is dropped, ".." pops, others push or error.
    always_comb begin
        fin_err = ST_OK;
        fin_ol  = ol_eff;
        fin_lvl = lvl_eff;
        push    = 1'b0;
        fin_wr  = 1'b0;
        if (r_dots && r_clen == ONE) begin
            fin_err = ST_OK;
        end else if (r_dots && r_clen == LW'(2)) begin
            if (lvl_eff != '0) begin
                fin_lvl = lvl_eff - VW'(1);
                fin_ol  = stack[lvl_eff - VW'(1)];
            end
        end else if (lvl_eff >= VFULL) begin
            fin_err = ST_RANGE;
        end else if (r_bad) begin
            fin_err = ST_INVALID;
        end else if (nout > LIM || sum > SW'(PATH_LIMIT) || sum >= SW'(r_cap)) begin
            fin_err = ST_RANGE;
        end else begin
            push    = 1'b1;
            fin_lvl = lvl_eff + VW'(1);
            fin_ol  = sum[LW-1:0];
            fin_wr  = (ol_eff != ONE) && (ol_eff < LIM);
        end
    end

    always_comb begin
        n_ol = r_ol; n_lvl = r_lvl; n_clen = r_clen; n_bad = r_bad; n_dots = r_dots;
        n_sidx = r_sidx; n_cerr = r_cerr; n_perr = r_perr;
        n_unroot = r_unroot; n_clong = r_clong; n_plong = r_plong;
        n_in_path = r_in_path; n_rel = r_rel; n_res_st = r_res_st; n_nlen = r_nlen;
        do_fin = 1'b0; we = 1'b0; wa = '0; wd = CH_SLASH; done = 1'b0;
        st = ST_OK;
        if (acc) begin
            if (i_char != CH_NUL) begin
                if (r_sidx == '0) begin
                    if (!r_in_path) begin
                        if (i_char != CH_SLASH) n_unroot = 1'b1;
                    end else if (i_char == CH_SLASH) begin
                        n_ol  = ONE;
                        n_lvl = '0;
                    end else begin
                        n_rel = 1'b1;
                    end
                end
                if (r_sidx <= LIM) n_sidx = r_sidx + ONE;
                if (err_cur == ST_OK) begin
                    if (i_char == CH_SLASH) begin
                        do_fin = (r_clen != '0);
                        n_clen = '0;
                        n_bad  = 1'b0;
                        n_dots = 1'b1;
                    end else begin
                        if (sum < SW'(PATH_LIMIT)) begin
                            we = 1'b1;
                            wa = sum[AW-1:0];
                            wd = i_char;
                        end
                        if (i_char < CH_SPACE || i_char == CH_DEL || i_char == CH_BSL) begin
                            n_bad = 1'b1;
                        end
                        if (i_char != CH_DOT) n_dots = 1'b0;
                        if (r_clen <= LIM) n_clen = r_clen + ONE;
                    end
                end
            end else begin
                if (r_sidx == '0 && !r_in_path) n_unroot = 1'b1;
                if (r_sidx > LIM) begin
                    if (r_in_path) n_plong = 1'b1;
                    else n_clong = 1'b1;
                end
                do_fin = (err_cur == ST_OK) && (r_clen != '0);
                n_clen = '0;
                n_bad  = 1'b0;
                n_dots = 1'b1;
                n_sidx = '0;
                n_in_path = 1'b1;
            end
            if (do_fin) begin
                n_ol  = fin_ol;
                n_lvl = fin_lvl;
                if (r_in_path) n_perr = fin_err;
                else n_cerr = fin_err;
                if (fin_wr) begin
                    we = 1'b1;
                    wa = ol_eff[AW-1:0];
                    wd = CH_SLASH;
                end
            end
            if (i_char == CH_NUL && r_in_path) begin
                done = 1'b1;
                priority if (r_cap == 7'd0) st = ST_INVALID;
                else if (n_unroot) st = ST_INVALID;
                else if (n_clong) st = ST_RANGE;
                else if (n_plong) st = ST_RANGE;
                else if (r_sidx == '0 || r_cap < 7'd2) st = ST_INVALID;
                else if (n_rel && n_cerr != ST_OK) st = n_cerr;
                else st = n_perr;
                n_res_st = st;
                n_nlen   = n_ol;
                n_ol = ONE; n_lvl = '0; n_cerr = ST_OK; n_perr = ST_OK;
                n_unroot = 1'b0; n_clong = 1'b0; n_plong = 1'b0;
                n_in_path = 1'b0; n_rel = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        if (acc && do_fin && push) stack[lvl_eff] <= ol_eff;
        r_rd <= mem[r_k[AW-1:0]];
        if (acc && done) r_nlen <= n_nlen;
        if (acc && done) r_res_st <= n_res_st;
        if (i_cmd.load) begin
            r_ochar <= (r_res_st != ST_OK) ? CH_NUL : ((r_k == '0) ? CH_SLASH : r_rd);
            r_olen  <= (r_res_st != ST_OK) ? 7'd0 : r_nlen[6:0];
            r_ost   <= r_res_st;
            r_olast <= (r_res_st != ST_OK) || (r_k + ONE == r_nlen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_ol <= ONE; r_lvl <= '0; r_clen <= '0; r_bad <= 1'b0; r_dots <= 1'b1;
            r_sidx <= '0; r_cerr <= ST_OK; r_perr <= ST_OK;
            r_unroot <= 1'b0; r_clong <= 1'b0; r_plong <= 1'b0;
            r_in_path <= 1'b0; r_rel <= 1'b0;
            r_k <= '0; r_ov <= 1'b0;
        end else begin
            if (i_cfg_wen) r_cap <= i_cfg_wdata;
            r_ol <= n_ol; r_lvl <= n_lvl; r_clen <= n_clen; r_bad <= n_bad;
            r_dots <= n_dots; r_sidx <= n_sidx; r_cerr <= n_cerr; r_perr <= n_perr;
            r_unroot <= n_unroot; r_clong <= n_clong; r_plong <= n_plong;
            r_in_path <= n_in_path; r_rel <= n_rel;
            if (acc && done) r_k <= '0;
            else if (i_cmd.load) r_k <= r_k + ONE;
            if (i_cmd.load) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    assign o_stat.path_done  = acc && done;
    assign o_stat.out_free   = !r_ov || i_out_ready;
    assign o_stat.err_result = (r_res_st != ST_OK);
    assign o_stat.emit_last  = (r_k + ONE == r_nlen);

    assign o_out_valid = r_ov;
    assign o_char      = r_ochar;
    assign o_len       = r_olen;
    assign o_status    = r_ost;
    assign o_last      = r_olast;

endmodule

>>> src/path_normalizer.sv
// ----------------------------------------------------------------------------
// path_normalizer
// Canonical absolute path builder from a directory string and a path string.
// ----------------------------------------------------------------------------
// Usage: feed the current directory bytes (tuser 0) ended by a zero byte,
// then the path bytes (tuser 1) ended by a zero byte, on the s_axis side.
// A word whose tuser does not match the expected string is dropped.
// Input words are taken one per cycle while no result is being drained.
// After the path's zero byte the block emits the normalized path on m_axis,
// one byte per word with tlast on the final one, or a single error word.
// Each result byte is drained as a store read, then an output load.
// The configuration write sets the caller's buffer capacity; it must only
// be changed while the block is idle, which the block itself does not
// enforce. Reset restores capacity 65 and empties all request state.
// When the receiver stalls, the output word holds and the drain waits;
// the next request may start as soon as the last word is loaded.
// ----------------------------------------------------------------------------
module path_normalizer #(
    parameter int PATH_LIMIT  = 64,
    parameter int LEVEL_LIMIT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [6:0]  i_cfg_wdata,     // output_capacity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] char_in
    input  logic        s_axis_tuser,    // is_path
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [7:0] char_out, [14:8] result_length
    output logic [1:0]  m_axis_tuser,    // status
    output logic        m_axis_tlast     // last_out
);
    import pn_pkg::*;

    t_cmd       cmd;
    t_stat      stat;
    logic [7:0] ch;
    logic [6:0] len;

    pn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pn_datapath #(
        .PATH_LIMIT  (PATH_LIMIT),
        .LEVEL_LIMIT (LEVEL_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .i_char      (s_axis_tdata),
        .i_is_path   (s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_char      (ch),
        .o_len       (len),
        .o_status    (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = {1'b0, len, ch};

endmodule
